### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/dtoi_pkg.sv
// ----------------------------------------------------------------------------
// dtoi_pkg
// Types and constants of the decimal text to integer converter.
// ----------------------------------------------------------------------------
package dtoi_pkg;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  localparam int MAG_W = 35;

  localparam logic [MAG_W-1:0] CAP_POS = 35'd2147483647;
  localparam logic [MAG_W-1:0] CAP_NEG = 35'd2147483648;
  // Largest magnitude the accumulator can ever hold.
  localparam logic [MAG_W-1:0] MAG_MAX = 35'd21474836489;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    phase_t             phase;
    logic               negative;
    logic [MAG_W-1:0]   magnitude;
  } dtoi_state_t;

  localparam dtoi_state_t STATE_RESET = '{phase: PH_SKIP, negative: 1'b0, magnitude: '0};

endpackage

### sv/decimal_text_to_int_saturating.sv
// ----------------------------------------------------------------------------
// decimal_text_to_int_saturating
// Streaming decimal text to signed 32-bit integer converter with saturation.
// ----------------------------------------------------------------------------
// One character request is taken every clock cycle when the result side keeps
// up. A character is registered on entry, the parser state is updated from it
// in the next cycle, and the character flagged last loads the saturated value
// into the output register, where the result is held until it is taken. The
// combinational state update (multiply by ten and add a digit) sets the rate
// of one character per cycle. A result waiting in the output register blocks
// only the next final character, and the input behind it while that character
// waits; other characters keep flowing.
module decimal_text_to_int_saturating (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value
);

`include "assert_macros.svh"

  logic                  s1_valid_r;
  logic [7:0]            ch_r;
  logic                  last_r;
  dtoi_pkg::dtoi_state_t state_r;
  dtoi_pkg::dtoi_state_t state_nxt;
  logic signed [31:0]    value_nxt;
  logic                  out_valid_r;
  logic signed [31:0]    out_value_r;
  logic                  out_free;
  logic                  s1_go;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!last_r || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  dtoi_step u_step (
    .ch        (ch_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .value     (value_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtoi_pkg::STATE_RESET;
    end else if (s1_go) begin
      state_r <= last_r ? dtoi_pkg::STATE_RESET : state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && last_r) begin
      out_value_r <= value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  `ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid_r, "result valid after reset")
  `ASSERT_CLK(a_last_makes_result, clk, rst_n, (s1_go && last_r) |=> out_valid_r, "final character produced no result")
  `ASSERT_CLK(a_stall_only_when_held, clk, rst_n, !in_ready |-> (s1_valid_r && last_r && out_valid_r), "input stalled without cause")
  `ASSERT_CLK(a_mag_bounded, clk, rst_n, state_r.magnitude <= dtoi_pkg::MAG_MAX, "magnitude beyond its bound")
  `ASSERT_CLK(a_state_clear_after_last, clk, rst_n, (s1_go && last_r) |=> (state_r == dtoi_pkg::STATE_RESET), "state not cleared after final character")

endmodule

### sv/dtoi_step.sv
// ----------------------------------------------------------------------------
// dtoi_step
// Per-character update of the parser state and the saturated result that
// the updated state would give if the string ended here.
// ----------------------------------------------------------------------------
module dtoi_step (
  input  logic [7:0]           ch,
  input  dtoi_pkg::dtoi_state_t state,
  output dtoi_pkg::dtoi_state_t state_nxt,
  output logic signed [31:0]   value
);

  logic                        is_blank;
  logic                        is_digit;
  logic                        is_sign;
  logic [dtoi_pkg::MAG_W-1:0]  cap_cur;
  logic [dtoi_pkg::MAG_W-1:0]  mag_add;
  logic [dtoi_pkg::MAG_W-1:0]  cap_nxt;
  logic [dtoi_pkg::MAG_W-1:0]  mag_clamp;
  logic [31:0]                 mag_low;

  assign is_blank = (ch == dtoi_pkg::CH_SPACE) ||
                    (ch inside {[dtoi_pkg::CH_TAB:dtoi_pkg::CH_CR]});
  assign is_digit = ch inside {[dtoi_pkg::CH_ZERO:dtoi_pkg::CH_NINE]};
  assign is_sign  = (ch == dtoi_pkg::CH_MINUS) || (ch == dtoi_pkg::CH_PLUS);

  // Accumulation freezes once the magnitude is past the cap, which bounds it.
  assign cap_cur = state.negative ? dtoi_pkg::CAP_NEG : dtoi_pkg::CAP_POS;
  always_comb begin
    if (state.magnitude <= cap_cur) begin
      mag_add = (state.magnitude << 3) + (state.magnitude << 1) +
                {{(dtoi_pkg::MAG_W-4){1'b0}}, ch[3:0]};
    end else begin
      mag_add = state.magnitude;
    end
  end

  // Next phase, sign and magnitude.
  always_comb begin
    state_nxt = state;
    case (state.phase)
      dtoi_pkg::PH_SKIP: begin
        if (is_blank) begin
          state_nxt.phase = dtoi_pkg::PH_SKIP;
        end else if (is_sign) begin
          state_nxt.phase    = dtoi_pkg::PH_DIGITS;
          state_nxt.negative = (ch == dtoi_pkg::CH_MINUS);
        end else if (is_digit) begin
          state_nxt.phase     = dtoi_pkg::PH_DIGITS;
          state_nxt.magnitude = mag_add;
        end else begin
          state_nxt.phase = dtoi_pkg::PH_DONE;
        end
      end
      dtoi_pkg::PH_DIGITS: begin
        if (is_digit) begin
          state_nxt.magnitude = mag_add;
        end else begin
          state_nxt.phase = dtoi_pkg::PH_DONE;
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

  // Clamp and apply the sign. The negative cap negates onto itself.
  assign cap_nxt   = state_nxt.negative ? dtoi_pkg::CAP_NEG : dtoi_pkg::CAP_POS;
  assign mag_clamp = (state_nxt.magnitude > cap_nxt) ? cap_nxt : state_nxt.magnitude;
  assign mag_low   = mag_clamp[31:0];
  assign value     = state_nxt.negative ? $signed(32'd0 - mag_low) : $signed(mag_low);

endmodule
